>>> rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg : shared types and constants for the dual stack shared memory
// Command codes, status codes, controller states and the control bundle
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int DEFAULT_DEPTH     = 128;
    localparam int DEFAULT_WORD_BITS = 32;

    localparam int COMMAND_BITS = 3;
    localparam int VALUE_BITS   = 32;
    localparam int STATUS_BITS  = 2;

    // command codes; the two spare codes are not members
    typedef enum logic [COMMAND_BITS-1:0] {
        CMD_PUSH_ONE = 3'd0,
        CMD_POP_ONE  = 3'd1,
        CMD_PEEK_ONE = 3'd2,
        CMD_PUSH_TWO = 3'd3,
        CMD_POP_TWO  = 3'd4,
        CMD_PEEK_TWO = 3'd5
    } cmd_code_t;

    localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic capture;   // take a new transaction into the datapath
        logic access;    // execute the held command against the memory
    } ctrl_t;

endpackage

>>> rtl/dss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ram : generic single-port RAM
// One write or read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ctrl : transaction sequencer
// Steps each transaction through capture, memory access and result.
// ----------------------------------------------------------------------------
module dss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output dss_pkg::ctrl_t ctrl
);

    import dss_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // accept the next transaction while the result is shown
                state_next = start ? ST_ACCESS : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        done         = 1'b0;
        ctrl.access  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_ACCESS:
            begin
                busy        = 1'b1;
                ctrl.access = 1'b1;
            end
            ST_RESULT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        ctrl.capture = start && !busy;
    end

endmodule

>>> rtl/dss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_datapath : stack pointers, shared memory and result registers
// Decodes the held command, checks fill and emptiness, drives the RAM.
// ----------------------------------------------------------------------------
module dss_datapath #(
    parameter int DEPTH     = dss_pkg::DEFAULT_DEPTH,
    parameter int WORD_BITS = dss_pkg::DEFAULT_WORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dss_pkg::ctrl_t                      ctrl,
    input  logic [dss_pkg::COMMAND_BITS-1:0]    command,
    input  logic signed [dss_pkg::VALUE_BITS-1:0] push_value,
    output logic signed [dss_pkg::VALUE_BITS-1:0] read_value,
    output logic [dss_pkg::STATUS_BITS-1:0]     status,
    output logic                                first_empty,
    output logic                                second_empty,
    output logic                                memory_full
);

    import dss_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] TOP_CNT    = CNT_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT    = CNT_W'(1);

    logic [COMMAND_BITS-1:0] cmd_reg;
    logic [WORD_BITS-1:0]    word_reg;
    logic [CNT_W-1:0]        first_reg;
    logic [CNT_W-1:0]        first_next;
    logic [CNT_W-1:0]        second_reg;
    logic [CNT_W-1:0]        second_next;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [STATUS_BITS-1:0]  status_next;
    logic                    hit_reg;
    logic                    hit_next;

    logic                    full;
    logic                    mem_we;
    logic [CNT_W-1:0]        addr_cnt;
    logic [WORD_BITS-1:0]    mem_rdata;
    logic [63:0]             push_wide;
    logic [63:0]             read_wide;

    assign push_wide = 64'($unsigned(push_value));

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= command;
            word_reg <= push_wide[WORD_BITS-1:0];
        end
    end

    assign full = ({1'b0, first_reg} + {1'b0, second_reg}) == DEPTH_SUM;

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        status_next = STAT_OK;
        hit_next    = 1'b0;
        mem_we      = 1'b0;
        addr_cnt    = '0;
        case (cmd_reg)
            CMD_PUSH_ONE:
            begin
                if (full)
                begin
                    status_next = STAT_OVERFLOW;
                end
                else
                begin
                    mem_we     = 1'b1;
                    addr_cnt   = first_reg;
                    first_next = first_reg + ONE_CNT;
                end
            end
            CMD_PUSH_TWO:
            begin
                if (full)
                begin
                    status_next = STAT_OVERFLOW;
                end
                else
                begin
                    mem_we      = 1'b1;
                    addr_cnt    = TOP_CNT - second_reg;
                    second_next = second_reg + ONE_CNT;
                end
            end
            CMD_POP_ONE, CMD_PEEK_ONE:
            begin
                if (first_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    hit_next = 1'b1;
                    addr_cnt = first_reg - ONE_CNT;
                    if (cmd_reg == CMD_POP_ONE)
                    begin
                        first_next = first_reg - ONE_CNT;
                    end
                end
            end
            CMD_POP_TWO, CMD_PEEK_TWO:
            begin
                if (second_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    hit_next = 1'b1;
                    addr_cnt = DEPTH_CNT - second_reg;
                    if (cmd_reg == CMD_POP_TWO)
                    begin
                        second_next = second_reg - ONE_CNT;
                    end
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            status_reg <= STAT_OK;
            hit_reg    <= 1'b0;
        end
        else if (ctrl.access)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    dss_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we && ctrl.access),
        .addr  (addr_cnt[ADDR_W-1:0]),
        .wdata (word_reg),
        .rdata (mem_rdata)
    );

    assign read_wide    = hit_reg ? 64'(mem_rdata) : 64'd0;
    assign read_value   = $signed(read_wide[VALUE_BITS-1:0]);
    assign status       = status_reg;
    assign first_empty  = (first_reg == '0);
    assign second_empty = (second_reg == '0);
    assign memory_full  = full;

endmodule

>>> rtl/dual_stack_shared_memory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory : two LIFO stacks in one shared RAM
// Stack one grows up from word 0, stack two down from the top word.
// Sequence: an accepted start moves to the access state, and the result
// strobe (done) is raised in the result state after it. start is not taken
// in the access state; it is taken while idle or while a result is shown.
// Reset: both stack counts clear; the RAM keeps its contents, uncleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory #(
    parameter int DEPTH     = dss_pkg::DEFAULT_DEPTH,
    parameter int WORD_BITS = dss_pkg::DEFAULT_WORD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [dss_pkg::COMMAND_BITS-1:0]      command,
    input  logic signed [dss_pkg::VALUE_BITS-1:0] push_value,
    output logic                                  done,
    output logic signed [dss_pkg::VALUE_BITS-1:0] read_value,
    output logic [dss_pkg::STATUS_BITS-1:0]       status,
    output logic                                  first_empty,
    output logic                                  second_empty,
    output logic                                  memory_full
);

    import dss_pkg::*;

    // Control bundle: capture latches the transaction, access runs it
    // against the RAM and advances the stack counts.
    ctrl_t ctrl;

    // Sequencer: idle -> access -> result, and straight back to access when
    // a new transaction arrives during the result cycle.
    dss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // Datapath: pointers, fill check, shared RAM and result registers.
    // Flags reflect the counts after the transaction, so they are valid
    // while done is high and hold until the next access.
    dss_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .command      (command),
        .push_value   (push_value),
        .read_value   (read_value),
        .status       (status),
        .first_empty  (first_empty),
        .second_empty (second_empty),
        .memory_full  (memory_full)
    );

`ifndef NO_ASSERTIONS
    // Every result strobe follows an access cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding access");

    // An accepted transaction always goes to the access cycle next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction not executed");

    // Overflow is reported only when the memory is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_OVERFLOW) |-> memory_full)
        else $error("overflow reported with free space");

    // An empty report leaves at least one stack empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (first_empty || second_empty))
        else $error("empty reported while both stacks hold entries");
`endif

endmodule
